@@ hdl/erl_pkg.sv @@
// Shared types and constants for the extent run list decoder.
// No dependencies; imported by every module of the block.
package erl_pkg;

   localparam int MAX_FIELD_BYTES = 8;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam logic [7:0] SPC_RESET = 8'd8;
   localparam logic [7:0] SIGN_BIT_MASK = 8'h80;

   typedef enum logic [1:0] {
      KIND_RUN = 2'd0,
      KIND_END = 2'd1,
      KIND_BAD = 2'd2,
      KIND_NEG = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] list_byte;
      logic       list_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] run_start_sector;
      logic [63:0] run_sector_count;
      logic [63:0] total_cluster_count;
   } rsp_type;

   // Classified run handed from the parser to the scaling stage.
   typedef struct packed {
      kind_type    kind;
      logic [63:0] cluster;
      logic [63:0] length;
      logic [63:0] total;
   } cmd_type;

endpackage

@@ hdl/erl_front.sv @@
// Byte parser: header decode, field assembly, cluster accumulation.
// Depends on erl_pkg; feeds erl_cmd_queue.
module erl_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  erl_pkg::req_type req_data,
   output logic            cmd_push,
   output erl_pkg::cmd_type cmd_data
);
   import erl_pkg::*;

   typedef enum logic [1:0] {
      PH_HALTED,
      PH_HEADER,
      PH_LENGTH,
      PH_OFFSET
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  left_ff, left_in;
   logic [2:0]  pos_ff, pos_in;
   logic [3:0]  off_size_ff, off_size_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] off_ff, off_in;
   logic [63:0] abs_ff, abs_in;
   logic [63:0] total_ff, total_in;

   always_comb begin
      phase_type   ph;
      logic [7:0]  b;
      logic [3:0]  len_size;
      logic [3:0]  off_size;
      logic [63:0] abs_cur;
      logic [63:0] total_cur;
      logic [63:0] shifted;
      logic [63:0] len_new;
      logic [63:0] off_new;
      logic        finish;
      logic [63:0] fin_len;
      logic [63:0] fin_off;
      logic [63:0] abs_new;
      logic [63:0] total_new;

      b         = req_data.list_byte;
      len_size  = b[3:0];
      off_size  = b[7:4];
      ph        = req_data.list_start ? PH_HEADER : phase_ff;
      abs_cur   = req_data.list_start ? 64'd0 : abs_ff;
      total_cur = req_data.list_start ? 64'd0 : total_ff;
      shifted   = 64'(b) << {pos_ff, 3'b000};
      len_new   = len_ff | shifted;
      off_new   = off_ff | shifted;
      finish    = 1'b0;
      fin_len   = len_ff;
      fin_off   = 64'd0;
      abs_new   = abs_cur;
      total_new = total_cur;

      phase_in    = phase_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      off_size_in = off_size_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      abs_in      = abs_ff;
      total_in    = total_ff;
      cmd_push    = 1'b0;
      cmd_data    = '{kind: KIND_END, cluster: 64'd0, length: 64'd0, total: total_cur};

      if (accept) begin
         abs_in   = abs_cur;
         total_in = total_cur;
         case (ph)
            PH_HEADER: begin
               if (b == 8'd0) begin
                  phase_in      = PH_HALTED;
                  cmd_push      = 1'b1;
                  cmd_data.kind = KIND_END;
               end else if (len_size == 4'd0 || len_size > 4'(MAX_FIELD_BYTES) ||
                            off_size > 4'(MAX_FIELD_BYTES)) begin
                  phase_in      = PH_HALTED;
                  cmd_push      = 1'b1;
                  cmd_data.kind = KIND_BAD;
               end else begin
                  left_in     = len_size;
                  off_size_in = off_size;
                  pos_in      = 3'd0;
                  len_in      = 64'd0;
                  off_in      = 64'd0;
                  phase_in    = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               len_in  = len_new;
               pos_in  = pos_ff + 3'd1;
               left_in = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  if (off_size_ff == 4'd0) begin
                     finish  = 1'b1;
                     fin_len = len_new;
                  end else begin
                     left_in  = off_size_ff;
                     pos_in   = 3'd0;
                     phase_in = PH_OFFSET;
                  end
               end
            end
            PH_OFFSET: begin
               off_in  = off_new;
               pos_in  = pos_ff + 3'd1;
               left_in = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  finish  = 1'b1;
                  fin_off = off_new;
                  // sign-extend a short offset field
                  if ((b & SIGN_BIT_MASK) != 8'd0 && off_size_ff < 4'd8)
                     fin_off = off_new | (~64'd0 << {off_size_ff[2:0], 3'b000});
               end
            end
            default: ;
         endcase

         if (finish) begin
            total_new = total_cur + fin_len;
            abs_new   = abs_cur + fin_off;
            total_in  = total_new;
            abs_in    = abs_new;
            cmd_push  = 1'b1;
            cmd_data  = '{kind: abs_new[63] ? KIND_NEG : KIND_RUN, cluster: abs_new,
                          length: fin_len, total: total_new};
            phase_in  = abs_new[63] ? PH_HALTED : PH_HEADER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HALTED;
         left_ff     <= 4'd0;
         pos_ff      <= 3'd0;
         off_size_ff <= 4'd0;
         len_ff      <= 64'd0;
         off_ff      <= 64'd0;
         abs_ff      <= 64'd0;
         total_ff    <= 64'd0;
      end else begin
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         pos_ff      <= pos_in;
         off_size_ff <= off_size_in;
         len_ff      <= len_in;
         off_ff      <= off_in;
         abs_ff      <= abs_in;
         total_ff    <= total_in;
      end
   end

endmodule

@@ hdl/erl_cmd_queue.sv @@
// Two-entry queue of classified runs between the parser and the scaling stage.
// Depends on erl_pkg.
module erl_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  erl_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output erl_pkg::cmd_type pop_data
);
   import erl_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push)
         slot_ff[wr_ff] <= push_data;
   end

endmodule

@@ hdl/erl_back.sv @@
// Scaling stage: clusters to sectors, result queue, sectors-per-cluster register.
// Depends on erl_pkg; drains erl_cmd_queue.
module erl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  erl_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output erl_pkg::rsp_type rsp_data
);
   import erl_pkg::*;

   logic [7:0]        spc_ff;
   rsp_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;
   logic [63:0]       start_prod;
   logic [63:0]       count_prod;
   rsp_type           scaled;

   assign csr_ready = 1'b1;
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = slot_ff[rd_ff];
   assign do_pop    = rsp_pop && !rsp_empty;
   assign cmd_pop   = !cmd_empty && (count_ff != QCNT_W'(QUEUE_DEPTH));

   assign start_prod = cmd_data.cluster * {56'd0, spc_ff};
   assign count_prod = cmd_data.length * {56'd0, spc_ff};

   always_comb begin
      scaled.result_kind         = cmd_data.kind;
      scaled.run_start_sector    = (cmd_data.kind == KIND_RUN) ? start_prod : 64'd0;
      scaled.run_sector_count    = (cmd_data.kind == KIND_RUN) ? count_prod : 64'd0;
      scaled.total_cluster_count = cmd_data.total;
   end

   always_comb begin
      wr_in    = cmd_pop ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (cmd_pop && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !cmd_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff   <= SPC_RESET;
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (csr_valid && csr_ready)
            spc_ff <= csr_data;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (cmd_pop)
         slot_ff[wr_ff] <= scaled;
   end

endmodule

@@ hdl/extent_run_list_decoder_unit.sv @@
// Top level of the extent run list decoder.
// Depends on erl_pkg, erl_front, erl_cmd_queue and erl_back.
//
// Usage:
//   Input channel (req_): the run list one byte a beat; list_start marks the
//   header byte of a new list and clears the cluster totals. A beat is taken
//   when req_push is high and req_full is low.
//   Result channel (rsp_): queue read side. The oldest result sits on rsp_data
//   while rsp_empty is low and leaves on a cycle with rsp_pop high.
//   Config (csr_): sectors-per-cluster write, always ready, taken when
//   csr_valid is high.
// Timing:
//   A byte that completes a run, ends the list or fails lands in the run queue
//   at the edge that takes it; the scaling multiply moves it into the result
//   queue when that queue has room, and it then shows on rsp_data. One byte
//   per cycle is sustained while req_full is low; the two-entry run queue
//   and the two-entry result queue keep both sides moving.
// Reset (synchronous): queues empty, parser halted until list_start,
//   sectors per cluster = 8.
// Stall: when results are not popped the result queue fills, then the run
//   queue, and req_full rises; nothing is dropped.
module extent_run_list_decoder_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  erl_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output erl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   import erl_pkg::*;

   logic    accept;
   logic    cmd_push;
   cmd_type cmd_in;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd_out;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   erl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   erl_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (cmd_out)
   );

   erl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/erl_checker.sv @@
// Port-level checks for extent_run_list_decoder_unit, attached by bind.
// Depends on erl_pkg.
module erl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input erl_pkg::req_type req_data,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input erl_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [7:0]       csr_data
);
   import erl_pkg::*;

   // queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // only a decoded run carries sector values
   a_zero_sectors: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.result_kind != KIND_RUN) |->
         (rsp_data.run_start_sector == 64'd0 && rsp_data.run_sector_count == 64'd0))
      else $error("non-run result with sector values");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result changed while stalled");

   // a result appears only after a byte has been taken and passed through the run queue
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_empty) && $past(rsp_empty, 2) && !$past(req_push && !req_full, 2)
       && !$past(reset, 2)) |-> rsp_empty)
      else $error("result appeared without input");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write not taken");

endmodule

bind extent_run_list_decoder_unit erl_checker u_erl_checker (.*);
